/* hdl/ipv4_prefix_trie_lookup_assert.svh */
// Assertion macros for the prefix trie lookup block.
`ifndef IPV4_PREFIX_TRIE_LOOKUP_ASSERT_SVH
`define IPV4_PREFIX_TRIE_LOOKUP_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition implies consequence in the same cycle.
`define IPT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Condition implies consequence in the next cycle.
`define IPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IPT_ASSERT_IMPLY(lbl, ante, cons)
`define IPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/ipt_pkg.sv */
// Shared types and constants of the prefix trie lookup block.
`default_nettype none
package ipt_pkg;
  localparam int unsigned STRIDE = 8;
  localparam int unsigned FANOUT = 256;
  localparam int unsigned LEN_W = 6;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOWHERE = 2'd2;

  localparam logic [1:0] LVL_LAST = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DRD  = 8'b0000_0010,
    S_DWT  = 8'b0000_0100,
    S_FILL = 8'b0000_1000,
    S_SRD  = 8'b0001_0000,
    S_SWT  = 8'b0010_0000,
    S_SADV = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;
endpackage
`default_nettype wire

/* hdl/ipt_entry_mem.sv */
// Entry table memory with root-node valid bits.
`default_nettype none
module ipt_entry_mem #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned NB = 8,
  parameter int unsigned EW = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ipt_pkg::mem_ctrl_t ctrl_i,
  input  wire logic [NB+7:0]    rd_addr_i,
  input  wire logic [NB+7:0]    wr_addr_i,
  input  wire logic [EW-1:0]    wr_data_i,
  output logic      [EW-1:0]    rd_data_o
);
  import ipt_pkg::*;

  localparam int unsigned DEPTH = MAX_NODES * FANOUT;

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_q;
  logic [FANOUT-1:0] root_vld_q;
  logic clr_q;

  // Write one entry and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Track written root entries; unwritten ones read as no-match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q <= '0;
      clr_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en && (wr_addr_i[NB+7:8] == '0)) begin
        root_vld_q[wr_addr_i[7:0]] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        clr_q <= (rd_addr_i[NB+7:8] == '0) && !root_vld_q[rd_addr_i[7:0]];
      end
    end
  end

  assign rd_data_o = clr_q ? '0 : rd_q;
endmodule
`default_nettype wire

/* hdl/ipv4_prefix_trie_lookup.sv */
// Lookup: a read and a wait state per trie level visited, then the result.
// Insert: a read and a wait state per level walked, a fill of each entry of every
// node opened, then read, wait and advance states per entry visited in the covered
// range and its subtrees and an advance per subtree left. One item at a time.
// Reset: root entries read as no-match through valid bits, one node in use,
// no clearing pass.
`default_nettype none
`include "ipv4_prefix_trie_lookup_assert.svh"
module ipv4_prefix_trie_lookup #(
  parameter int unsigned MAX_NODES = 256,
  parameter int unsigned CLASS_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [31:0] address_i,
  input  wire logic [5:0]  prefix_len_i,
  input  wire logic [7:0]  class_id_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  match_class_o,
  output logic      [5:0]  match_len_o,
  output logic      [1:0]  status_o
);
  import ipt_pkg::*;

  localparam int unsigned CB = CLASS_BITS;
  localparam int unsigned NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NU_W = $clog2(MAX_NODES + 1);
  localparam int unsigned LEAF_W = LEN_W + CB;
  localparam int unsigned PW = (LEAF_W > NB) ? LEAF_W : NB;
  localparam int unsigned EW = PW + 1;

  state_e state_q, state_d;
  logic func_q, func_d;
  logic [31:0] addr_q, addr_d;
  logic [5:0] len_q, len_d;
  logic [CB-1:0] cls_q, cls_d;
  logic [1:0] lvl_q, lvl_d, top_q, top_d;
  logic [NB-1:0] node_q [4];
  logic [NB-1:0] node_d [4];
  logic [7:0] idx_q [4];
  logic [7:0] idx_d [4];
  logic [7:0] last_q, last_d;
  logic [NU_W-1:0] nused_q, nused_d;
  logic [7:0] fcnt_q, fcnt_d;
  logic [EW-1:0] fval_q, fval_d;
  logic [NB-1:0] fresh_q, fresh_d;
  logic used_q, used_d;
  logic [CB-1:0] rcls_q, rcls_d;
  logic [5:0] rlen_q, rlen_d;
  logic [1:0] rst_q, rst_d;

  mem_ctrl_t mctl;
  logic [NB+7:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic [CB+7:0] cls_ext;
  logic [CB+7:0] rcls_ext;
  logic [1:0] nl;
  logic e_child;
  logic [NB-1:0] e_ptr;
  logic [5:0] e_len;
  logic [CB-1:0] e_cls;
  logic [EW-1:0] leaf_w;

  // Byte of the address used at one level
  function automatic logic [7:0] byte_f(logic [31:0] a, logic [1:0] l);
    logic [7:0] b;
    case (l)
      2'd0: b = a[31:24];
      2'd1: b = a[23:16];
      2'd2: b = a[15:8];
      default: b = a[7:0];
    endcase
    return b;
  endfunction

  // Mask of prefix bits within the byte of level l
  function automatic logic [7:0] mask_f(logic [5:0] len, logic [1:0] l);
    logic [5:0] rem;
    logic [3:0] sh;
    rem = len - {1'b0, l, 3'b000};
    sh = 4'd8 - rem[3:0];
    return 8'hFF << sh;
  endfunction

  // Length bound above which an insert walks past level l
  function automatic logic [5:0] thr_f(logic [1:0] l);
    logic [2:0] n;
    n = {1'b0, l} + 3'd1;
    return {n, 3'b000};
  endfunction

  assign cls_ext = {{CB{1'b0}}, class_id_i};
  assign nl = lvl_q + 2'd1;
  assign e_child = rd_data[EW-1];
  assign e_ptr = rd_data[NB-1:0];
  assign e_len = rd_data[LEAF_W-1:CB];
  assign e_cls = rd_data[CB-1:0];
  assign leaf_w = EW'({len_q, cls_q});

  // Sequencer: walk, open nodes, scan and push the new leaf
  always_comb begin
    logic [7:0] m;
    state_d = state_q;
    func_d = func_q;
    addr_d = addr_q;
    len_d = len_q;
    cls_d = cls_q;
    lvl_d = lvl_q;
    top_d = top_q;
    node_d = node_q;
    idx_d = idx_q;
    last_d = last_q;
    nused_d = nused_q;
    fcnt_d = fcnt_q;
    fval_d = fval_q;
    fresh_d = fresh_q;
    used_d = used_q;
    rcls_d = rcls_q;
    rlen_d = rlen_q;
    rst_d = rst_q;
    mctl = '0;
    rd_addr = {node_q[lvl_q], idx_q[lvl_q]};
    wr_addr = {node_q[lvl_q], idx_q[lvl_q]};
    wr_data = leaf_w;
    m = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          addr_d = address_i;
          len_d = prefix_len_i;
          cls_d = cls_ext[CB-1:0];
          lvl_d = 2'd0;
          node_d[0] = '0;
          used_d = 1'b0;
          rcls_d = '0;
          rlen_d = '0;
          rst_d = ST_OK;
          if (func_i == FUNC_LOOKUP) begin
            state_d = S_DRD;
          end else if (prefix_len_i == 6'd0 || prefix_len_i > 6'd32) begin
            rst_d = ST_NOWHERE;
            state_d = S_OUT;
          end else if (prefix_len_i > thr_f(2'd0)) begin
            state_d = S_DRD;
          end else begin
            m = mask_f(prefix_len_i, 2'd0);
            top_d = 2'd0;
            idx_d[0] = address_i[31:24] & m;
            last_d = address_i[31:24] | ~m;
            state_d = S_SRD;
          end
        end
      end
      S_DRD: begin
        mctl.rd_en = 1'b1;
        rd_addr = {node_q[lvl_q], byte_f(addr_q, lvl_q)};
        state_d = S_DWT;
      end
      S_DWT: begin
        if (func_q == FUNC_LOOKUP) begin
          if (!e_child) begin
            rcls_d = e_cls;
            rlen_d = e_len;
            state_d = S_OUT;
          end else if (lvl_q == LVL_LAST) begin
            state_d = S_OUT;
          end else begin
            node_d[nl] = e_ptr;
            lvl_d = nl;
            state_d = S_DRD;
          end
        end else if (e_child) begin
          node_d[nl] = e_ptr;
          lvl_d = nl;
          if (len_q > thr_f(nl)) begin
            state_d = S_DRD;
          end else begin
            m = mask_f(len_q, nl);
            top_d = nl;
            idx_d[nl] = byte_f(addr_q, nl) & m;
            last_d = byte_f(addr_q, nl) | ~m;
            state_d = S_SRD;
          end
        end else if (nused_q >= NU_W'(MAX_NODES)) begin
          rst_d = ST_FULL;
          state_d = S_OUT;
        end else begin
          // Point the parent entry at a fresh node, then fill it
          mctl.wr_en = 1'b1;
          wr_addr = {node_q[lvl_q], byte_f(addr_q, lvl_q)};
          wr_data = {1'b1, PW'(nused_q[NB-1:0])};
          fresh_d = nused_q[NB-1:0];
          nused_d = nused_q + NU_W'(1);
          fval_d = rd_data;
          fcnt_d = '0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        mctl.wr_en = 1'b1;
        wr_addr = {fresh_q, fcnt_q};
        wr_data = fval_q;
        fcnt_d = fcnt_q + 8'd1;
        if (fcnt_q == 8'hFF) begin
          node_d[nl] = fresh_q;
          lvl_d = nl;
          if (len_q > thr_f(nl)) begin
            state_d = S_DRD;
          end else begin
            m = mask_f(len_q, nl);
            top_d = nl;
            idx_d[nl] = byte_f(addr_q, nl) & m;
            last_d = byte_f(addr_q, nl) | ~m;
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        mctl.rd_en = 1'b1;
        state_d = S_SWT;
      end
      S_SWT: begin
        state_d = S_SADV;
        if (e_child) begin
          if (lvl_q != LVL_LAST) begin
            node_d[nl] = e_ptr;
            idx_d[nl] = '0;
            lvl_d = nl;
            state_d = S_SRD;
          end
        end else if (e_len < len_q) begin
          mctl.wr_en = 1'b1;
          used_d = 1'b1;
        end
      end
      S_SADV: begin
        // Advance the index, or pop back to the parent level
        if (idx_q[lvl_q] != ((lvl_q == top_q) ? last_q : 8'hFF)) begin
          idx_d[lvl_q] = idx_q[lvl_q] + 8'd1;
          state_d = S_SRD;
        end else if (lvl_q == top_q) begin
          rst_d = used_q ? ST_OK : ST_NOWHERE;
          state_d = S_OUT;
        end else begin
          lvl_d = lvl_q - 2'd1;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nused_q <= NU_W'(1);
      lvl_q <= '0;
    end else begin
      state_q <= state_d;
      nused_q <= nused_d;
      lvl_q <= lvl_d;
    end
  end

  // Hold item payload and walk registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    addr_q <= addr_d;
    len_q <= len_d;
    cls_q <= cls_d;
    top_q <= top_d;
    node_q <= node_d;
    idx_q <= idx_d;
    last_q <= last_d;
    fcnt_q <= fcnt_d;
    fval_q <= fval_d;
    fresh_q <= fresh_d;
    used_q <= used_d;
    rcls_q <= rcls_d;
    rlen_q <= rlen_d;
    rst_q <= rst_d;
  end

  ipt_entry_mem #(
    .MAX_NODES(MAX_NODES),
    .NB(NB),
    .EW(EW)
  ) u_mem (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  assign rcls_ext = {8'b0, rcls_q};
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign match_class_o = rcls_ext[7:0];
  assign match_len_o = rlen_q;
  assign status_o = rst_q;

  `IPT_ASSERT_IMPLY(a_nodes_bound, 1'b1, nused_q <= NU_W'(MAX_NODES))
  `IPT_ASSERT_IMPLY(a_one_item, in_ready_o, !out_valid_o)
  `IPT_ASSERT_NEXT(a_out_to_idle, out_valid_o && out_ready_i, in_ready_o)
  `IPT_ASSERT_IMPLY(a_lookup_ok, out_valid_o && func_q == FUNC_LOOKUP, status_o == ST_OK)
endmodule
`default_nettype wire

/* bench/ipv4_prefix_trie_lookup_tb.sv */
// Self-checking testbench for the IPv4 prefix trie lookup block.
`default_nettype none
module ipv4_prefix_trie_lookup_tb;
  import ipt_pkg::*;

  localparam int unsigned NODES      = 256;
  localparam int unsigned LEVELS     = 4;
  localparam logic [31:0] CHILD_BIT  = 32'h8000_0000;
  localparam int unsigned RAND_ITEMS = 1000;
  localparam int unsigned QUIET_TAIL = 100;
  localparam int unsigned WDOG_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0] cls;
    logic [5:0] len;
    logic [1:0] st;
  } answer_t;

  typedef struct packed {
    logic        fn;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [7:0]  cls;
    logic        typed;
    answer_t     ans;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = FUNC_LOOKUP;
  logic [31:0] address_i = '0;
  logic [5:0]  prefix_len_i = '0;
  logic [7:0]  class_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  match_class_o;
  logic [5:0]  match_len_o;
  logic [1:0]  status_o;

  // Trie mirror: leaf = {len, class}, child = CHILD_BIT | node
  logic [31:0] trie_mem [NODES*FANOUT];
  int unsigned node_count;
  answer_t     pending_q[$];
  int unsigned err_cnt = 0;
  bit          quiet = 1'b0;
  bit          gap_en = 1'b1;
  logic [7:0]  pool0 [4];
  logic [7:0]  pool1 [4];
  logic [7:0]  pool2 [8];
  row_t        rows [$];

  ipv4_prefix_trie_lookup dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [5:0] leaf_len(logic [31:0] e);
    return e[13:8];
  endfunction

  // Push a leaf into every shorter entry of a subtree
  function automatic bit spread_leaf(int unsigned node, int unsigned lvl,
                                     logic [31:0] leaf, logic [5:0] len);
    bit hit;
    logic [31:0] e;
    hit = 1'b0;
    for (int i = 0; i < FANOUT; i++) begin
      e = trie_mem[node*FANOUT + i];
      if (e & CHILD_BIT) begin
        if (lvl + 1 < LEVELS && spread_leaf({16'd0, e[15:0]}, lvl + 1, leaf, len)) hit = 1'b1;
      end else if (leaf_len(e) < len) begin
        trie_mem[node*FANOUT + i] = leaf;
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [1:0] add_prefix(logic [31:0] addr, logic [5:0] len,
                                            logic [7:0] cls);
    logic [31:0] leaf, e;
    int unsigned node, lvl, rem, shift, b, span;
    bit hit;
    node = 0; lvl = 0; rem = {26'd0, len}; shift = 32; hit = 1'b0;
    if (len == 0 || len > 32) return ST_NOWHERE;
    addr &= 32'hFFFF_FFFF << (32 - len);
    leaf = {18'd0, len, cls};
    while (rem > STRIDE) begin
      b = (addr >> (shift - STRIDE)) & 8'hFF;
      e = trie_mem[node*FANOUT + b];
      if (e & CHILD_BIT) begin
        node = {16'd0, e[15:0]};
      end else begin
        if (node_count >= NODES) return ST_FULL;
        for (int k = 0; k < FANOUT; k++) trie_mem[node_count*FANOUT + k] = e;
        trie_mem[node*FANOUT + b] = CHILD_BIT | node_count;
        node = node_count;
        node_count++;
      end
      shift -= STRIDE; rem -= STRIDE; lvl++;
    end
    b = (addr >> (shift - STRIDE)) & 8'hFF;
    span = 1 << (STRIDE - rem);
    for (int unsigned i = b; i < b + span && i < FANOUT; i++) begin
      e = trie_mem[node*FANOUT + i];
      if (e & CHILD_BIT) begin
        if (lvl + 1 < LEVELS && spread_leaf({16'd0, e[15:0]}, lvl + 1, leaf, len)) hit = 1'b1;
      end else if (leaf_len(e) < len) begin
        trie_mem[node*FANOUT + i] = leaf;
        hit = 1'b1;
      end
    end
    return hit ? ST_OK : ST_NOWHERE;
  endfunction

  function automatic answer_t find_prefix(logic [31:0] addr);
    int unsigned node;
    logic [31:0] e;
    node = 0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      e = trie_mem[node*FANOUT + addr[31 - 8*lvl -: 8]];
      if (!(e & CHILD_BIT)) return '{cls: e[7:0], len: leaf_len(e), st: ST_OK};
      node = {16'd0, e[15:0]};
    end
    return '0;
  endfunction

  // Present one item, hold it until accepted, then queue its answer
  task automatic send(row_t r);
    answer_t a;
    in_valid_i   <= 1'b1;
    func_i       <= r.fn;
    address_i    <= r.addr;
    prefix_len_i <= r.plen;
    class_id_i   <= r.cls;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.fn == FUNC_INSERT) a = '{cls: 8'd0, len: 6'd0, st: add_prefix(r.addr, r.plen, r.cls)};
    else a = find_prefix(r.addr);
    if (r.typed) a = r.ans;
    pending_q.push_back(a);
    if (gap_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return {pool0[$urandom_range(0, 3)], pool1[$urandom_range(0, 3)],
            pool2[$urandom_range(0, 7)], 8'($urandom)};
  endfunction

  function automatic logic [5:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return 6'($urandom_range(1, 8));
    if (r < 5) return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
    if (r < 30) return 6'($urandom_range(9, 16));
    return 6'($urandom_range(17, 32));
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    answer_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result class=%0d len=%0d status=%0d", $time,
                 match_class_o, match_len_o, status_o);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (match_class_o !== want.cls) begin
          $display("%0t: match_class expected %0d actual %0d", $time, want.cls,
                   match_class_o);
          err_cnt++;
        end
        if (match_len_o !== want.len) begin
          $display("%0t: match_len expected %0d actual %0d", $time, want.len, match_len_o);
          err_cnt++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // End the run after too long without any handshake
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (idle >= WDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    row_t r;
    for (int i = 0; i < NODES*FANOUT; i++) trie_mem[i] = '0;
    node_count = 1;
    foreach (pool0[i]) pool0[i] = 8'($urandom);
    foreach (pool1[i]) pool1[i] = 8'($urandom);
    foreach (pool2[i]) pool2[i] = 8'($urandom);

    // fn, addr, len, class, typed, {class, len, status}
    rows = '{
      '{FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'd0,   1'b1, '{8'd0, 6'd0, ST_OK}},
      '{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF,  1'b1, '{8'd0, 6'd0, ST_OK}},
      '{FUNC_INSERT, 32'h0A00_0000, 6'd0,  8'd9,   1'b1, '{8'd0, 6'd0, ST_NOWHERE}},
      '{FUNC_INSERT, 32'h0A00_0000, 6'd33, 8'd9,   1'b1, '{8'd0, 6'd0, ST_NOWHERE}},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF,  1'b1, '{8'd0, 6'd0, ST_NOWHERE}},
      '{FUNC_INSERT, 32'h0A12_3456, 6'd8,  8'd5,   1'b1, '{8'd0, 6'd0, ST_OK}},
      '{FUNC_INSERT, 32'h0A00_0000, 6'd8,  8'd6,   1'b1, '{8'd0, 6'd0, ST_NOWHERE}},
      '{FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  8'd0,   1'b1, '{8'd5, 6'd8, ST_OK}},
      '{FUNC_INSERT, 32'h0A01_FFFF, 6'd16, 8'd7,   1'b0, '0},
      '{FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_LOOKUP, 32'h0A02_0203, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_INSERT, 32'h0A01_0203, 6'd32, 8'hFF,  1'b0, '0},
      '{FUNC_INSERT, 32'h0A01_0280, 6'd25, 8'd0,   1'b0, '0},
      '{FUNC_LOOKUP, 32'h0A01_02F0, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_INSERT, 32'h0000_0000, 6'd1,  8'd1,   1'b0, '0},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 6'd1,  8'd2,   1'b0, '0},
      '{FUNC_LOOKUP, 32'h0A01_0204, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_LOOKUP, 32'hC000_0001, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 6'd24, 8'hAA,  1'b0, '0},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h55,  1'b0, '0},
      '{FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'd0,   1'b0, '0},
      '{FUNC_LOOKUP, 32'hFFFF_FF00, 6'd0,  8'd0,   1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i]);

    // Random traffic: half inserts, half lookups over shared address pools
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_TAIL) begin
        quiet = 1'b1;
        gap_en = 1'b0;
      end
      r.fn    = $urandom_range(0, 1) ? FUNC_LOOKUP : FUNC_INSERT;
      r.addr  = pick_addr();
      r.plen  = (r.fn == FUNC_INSERT) ? pick_len() : 6'($urandom);
      r.cls   = ($urandom_range(0, 49) == 0) ? 8'd0 : 8'($urandom);
      r.typed = 1'b0;
      r.ans   = '0;
      send(r);
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
